// File: hdl/srfc_pkg.sv
package srfc_pkg;

	localparam int unsigned MAX_REPLY = 64;

	localparam logic [6:0]  COUNT_SAT = 7'd127;
	localparam logic [15:0] CRC_START = 16'hffff;
	localparam logic [15:0] CRC_POLY  = 16'ha001;

	localparam logic [6:0] MAX_REPLY_LEN = 7'(MAX_REPLY);
	localparam logic [6:0] MIN_REPLY_LEN = 7'd2;
	localparam logic [2:0] MAX_VALUE_SIZE = 3'd4;

	localparam logic [7:0] RST_EXP_ADDR  = 8'hfe;
	localparam logic [7:0] RST_EXP_FUNC  = 8'h44;
	localparam logic [6:0] RST_REPLY_LEN = 7'd7;
	localparam logic [5:0] RST_VALUE_POS = 6'd3;
	localparam logic [2:0] RST_VALUE_SIZE = 3'd2;

	typedef enum logic [2:0] {
		CFG_EXP_ADDR   = 3'd0,
		CFG_EXP_FUNC   = 3'd1,
		CFG_REPLY_LEN  = 3'd2,
		CFG_VALUE_POS  = 3'd3,
		CFG_VALUE_SIZE = 3'd4
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_LENGTH  = 2'd1,
		ST_HEADER  = 2'd2,
		ST_CRC     = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] expected_address;
		logic [7:0] expected_function;
		logic [6:0] reply_length;
		logic [5:0] value_position;
		logic [2:0] value_size;
	} cfg_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// File: hdl/srfc_in_if.sv
interface srfc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       last_byte;

	modport source(output valid, output rx_byte, output last_byte, input ready);
	modport sink(input valid, input rx_byte, input last_byte, output ready);
endinterface

// File: hdl/srfc_out_if.sv
interface srfc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] value;

	modport source(output valid, output status, output value, input ready);
	modport sink(input valid, input status, input value, output ready);
endinterface

// File: hdl/srfc_frame.sv
module srfc_frame #(
	parameter int unsigned MAX_REPLY = srfc_pkg::MAX_REPLY
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        rx_byte,
	input  logic              last_byte,
	input  srfc_pkg::cfg_t    cfg,
	output srfc_pkg::status_t status,
	output logic [31:0]       value
);
	import srfc_pkg::*;

	localparam logic [6:0] MAX_LEN = 7'(MAX_REPLY);

	logic [6:0]  count_q;
	logic [15:0] crc_q;
	logic [15:0] rx_crc_q;
	logic        hdr_bad_q;
	logic [31:0] acc_q;

	logic        sat;
	logic [2:0]  size;
	logic [6:0]  val_end;
	logic        in_value;
	logic [6:0]  count_d;
	logic [15:0] crc_d;
	logic [15:0] rx_crc_d;
	logic        hdr_bad_d;
	logic [31:0] acc_d;
	logic [7:0]  len_seen;
	logic        len_bad;

	always_comb begin
		sat      = (count_q == COUNT_SAT);
		size     = (cfg.value_size > MAX_VALUE_SIZE) ? MAX_VALUE_SIZE : cfg.value_size;
		val_end  = {1'b0, cfg.value_position} + {4'd0, size};
		in_value = (size != 3'd0) && (count_q >= {1'b0, cfg.value_position})
			&& (count_q < val_end);

		hdr_bad_d = hdr_bad_q;
		acc_d     = acc_q;
		crc_d     = crc_q;
		if (!sat) begin
			if (count_q == 7'd0 && rx_byte != cfg.expected_address) begin
				hdr_bad_d = 1'b1;
			end
			if (count_q == 7'd1 && rx_byte != cfg.expected_function) begin
				hdr_bad_d = 1'b1;
			end
			if (in_value) begin
				acc_d = {acc_q[23:0], rx_byte};
			end
			if (count_q >= 7'd2) begin
				crc_d = crc_byte(crc_q, rx_crc_q[7:0]);
			end
		end
		rx_crc_d = {rx_byte, rx_crc_q[15:8]};
		count_d  = sat ? COUNT_SAT : count_q + 7'd1;

		len_seen = {1'b0, count_q} + 8'd1;
		len_bad  = sat || (len_seen != {1'b0, cfg.reply_length})
			|| (cfg.reply_length < MIN_REPLY_LEN) || (cfg.reply_length > MAX_LEN);
	end

	always_comb begin
		priority if (len_bad) begin
			status = ST_LENGTH;
		end else if (hdr_bad_d) begin
			status = ST_HEADER;
		end else if (crc_d != rx_crc_d) begin
			status = ST_CRC;
		end else begin
			status = ST_OK;
		end
		value = (status == ST_OK) ? acc_d : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= 7'd0;
			crc_q     <= CRC_START;
			rx_crc_q  <= 16'd0;
			hdr_bad_q <= 1'b0;
			acc_q     <= 32'd0;
		end else if (accept) begin
			if (last_byte) begin
				count_q   <= 7'd0;
				crc_q     <= CRC_START;
				rx_crc_q  <= 16'd0;
				hdr_bad_q <= 1'b0;
				acc_q     <= 32'd0;
			end else begin
				count_q   <= count_d;
				crc_q     <= crc_d;
				rx_crc_q  <= rx_crc_d;
				hdr_bad_q <= hdr_bad_d;
				acc_q     <= acc_d;
			end
		end
	end

endmodule

// File: hdl/sensor_reply_frame_checker_top.sv
// output: the result of a frame is registered and appears on out_ch in the cycle after its last byte is accepted
// throughput: one byte per cycle; a waiting result stalls input only if out_ch is not ready
// the cycle time is set by the eight unrolled crc bit steps and the status compare
// reset: async active low; clears frame state, the output register and loads the
// default configuration
module sensor_reply_frame_checker_top #(
	parameter int unsigned MAX_REPLY = srfc_pkg::MAX_REPLY
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_wdata,
	srfc_in_if.sink    in_ch,
	srfc_out_if.source out_ch
);
	import srfc_pkg::*;

	cfg_t        cfg_q;
	logic        accept;
	status_t     status;
	logic [31:0] value;
	logic        out_valid_q;
	status_t     status_q;
	logic [31:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_address  <= RST_EXP_ADDR;
			cfg_q.expected_function <= RST_EXP_FUNC;
			cfg_q.reply_length      <= RST_REPLY_LEN;
			cfg_q.value_position    <= RST_VALUE_POS;
			cfg_q.value_size        <= RST_VALUE_SIZE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_EXP_ADDR:   cfg_q.expected_address  <= cfg_wdata;
				CFG_EXP_FUNC:   cfg_q.expected_function <= cfg_wdata;
				CFG_REPLY_LEN:  cfg_q.reply_length      <= cfg_wdata[6:0];
				CFG_VALUE_POS:  cfg_q.value_position    <= cfg_wdata[5:0];
				CFG_VALUE_SIZE: cfg_q.value_size        <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	srfc_frame #(
		.MAX_REPLY (MAX_REPLY)
	) u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (in_ch.rx_byte),
		.last_byte (in_ch.last_byte),
		.cfg       (cfg_q),
		.status    (status),
		.value     (value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && in_ch.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= ST_OK;
			value_q  <= 32'd0;
		end else if (accept && in_ch.last_byte) begin
			status_q <= status;
			value_q  <= value;
		end
	end

	assign out_ch.valid  = out_valid_q;
	assign out_ch.status = status_q;
	assign out_ch.value  = value_q;

endmodule
